// ----- rtl/lhbm_pkg.sv -----
// Shared types and constants for the left-half block mosaic.
// Holds the frame and tile geometry, opcodes, controller states and the
// command and status structs between the controller and the datapath.
package lhbm_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int TILE_SIZE  = 16;
  localparam int TILE_SHIFT = $clog2(TILE_SIZE);
  localparam int TILE_COLS  = (MAX_WIDTH / 2 + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TILE_ROWS  = (MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int NUM_TILES  = TILE_COLS * TILE_ROWS;
  localparam int TILE_AW    = $clog2(NUM_TILES);
  localparam int FS_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int FS_AW      = $clog2(FS_DEPTH);

  localparam int COORD_W = 9;
  localparam int CFG_W   = 10;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 32;
  localparam int DIV_W   = SUM_W + CH_W;
  localparam int DCNT_W  = $clog2(CH_W);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_WRITE,
    S_ACCUM,
    S_READ,
    S_SELECT,
    S_DIV,
    S_DONE
  } state_t;

  // Channel 0 is red, 1 green, 2 blue.
  typedef logic [2:0][CH_W-1:0] pix_t;

  typedef struct packed {
    logic [SUM_W-1:0]        cnt;
    logic [2:0][SUM_W-1:0]   sum;
  } tile_entry_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic fs_write;
    logic tile_acc;
    logic select;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_oor;
    logic mosaic;
    logic cnt_zero;
    logic sweep_last;
    logic div_last;
  } dp_stat_t;

endpackage

// ----- rtl/lhbm_dp.sv -----
// Datapath of the left-half block mosaic: configuration registers, frame
// store, tile sum memory, restoring divider and result registers.
// Depends on lhbm_pkg; driven by the commands of lhbm_ctrl.
module lhbm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lhbm_pkg::ctrl_cmd_t           cmd,
  output lhbm_pkg::dp_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [lhbm_pkg::CFG_W-1:0]    cfg_data,
  input  logic [1:0]                    in_opcode,
  input  logic [lhbm_pkg::COORD_W-1:0]  in_col,
  input  logic [lhbm_pkg::COORD_W-1:0]  in_row,
  input  logic [lhbm_pkg::CH_W-1:0]     in_red_in,
  input  logic [lhbm_pkg::CH_W-1:0]     in_green_in,
  input  logic [lhbm_pkg::CH_W-1:0]     in_blue_in,
  output logic [lhbm_pkg::CH_W-1:0]     out_red_out,
  output logic [lhbm_pkg::CH_W-1:0]     out_green_out,
  output logic [lhbm_pkg::CH_W-1:0]     out_blue_out,
  output logic                          out_out_of_range
);
  import lhbm_pkg::*;

  localparam int TC_W = COORD_W - TILE_SHIFT;

  logic [CFG_W-1:0]   width_r, height_r;
  logic [CFG_W-1:0]   eff_w, eff_h;
  logic [TC_W-1:0]    tcol, trow;
  logic               oor_c, mosaic_c;
  logic [TILE_AW-1:0] tile_c;

  logic               mosaic_r;
  logic [TILE_AW-1:0] tile_r;
  logic [FS_AW-1:0]   addr_r;
  pix_t               pix_r;

  pix_t               fs_mem [FS_DEPTH];
  pix_t               fs_rd_r;
  tile_entry_t        tm_mem [NUM_TILES];
  tile_entry_t        tm_rd_r;
  tile_entry_t        tm_wd;
  logic [TILE_AW-1:0] tm_addr;
  logic               tm_we;
  logic [TILE_AW-1:0] sweep_r;

  logic [DIV_W-1:0]   d_r;
  logic [SUM_W-1:0]   rem_r [3];
  logic [CH_W-1:0]    q_r [3];
  logic [2:0]         sat_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [2:0]         ge;

  pix_t               res_r;
  logic               res_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_WIDTH);
      height_r <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
    end
  end

  always_comb begin
    eff_w    = (width_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;
    eff_h    = (height_r > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_r;
    tcol     = in_col[COORD_W-1:TILE_SHIFT];
    trow     = in_row[COORD_W-1:TILE_SHIFT];
    oor_c    = ({1'b0, in_col} >= eff_w) || ({1'b0, in_row} >= eff_h);
    mosaic_c = ({1'b0, tcol, {TILE_SHIFT{1'b0}}} < (eff_w >> 1))
               && (32'(tcol) < TILE_COLS) && (32'(trow) < TILE_ROWS);
    tile_c   = TILE_AW'(32'(trow) * TILE_COLS + 32'(tcol));
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mosaic_r <= mosaic_c;
      tile_r   <= tile_c;
      addr_r   <= FS_AW'({in_row, in_col});
      pix_r    <= {in_blue_in, in_green_in, in_red_in};
    end
  end

  // Frame store, one port, registered read.
  always_ff @(posedge clk) begin
    if (cmd.fs_write) begin
      fs_mem[addr_r] <= pix_r;
    end
    fs_rd_r <= fs_mem[addr_r];
  end

  always_comb begin
    tm_addr = cmd.sweep ? sweep_r : tile_r;
    tm_we   = cmd.sweep || cmd.tile_acc;
    tm_wd   = '0;
    if (!cmd.sweep) begin
      tm_wd.cnt = tm_rd_r.cnt + SUM_W'(1);
      for (int k = 0; k < 3; k++) begin
        tm_wd.sum[k] = tm_rd_r.sum[k] + SUM_W'(pix_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tm_mem[tm_addr] <= tm_wd;
    end
    tm_rd_r <= tm_mem[tm_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.accept) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_r + TILE_AW'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ge[k] = ({{CH_W{1'b0}}, rem_r[k]} >= d_r);
    end
  end

  // Quotients above the channel range saturate, so only eight quotient
  // bits are ever developed, one per cycle.
  always_ff @(posedge clk) begin
    if (cmd.select) begin
      d_r    <= DIV_W'(tm_rd_r.cnt) << (CH_W - 1);
      dcnt_r <= '0;
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= tm_rd_r.sum[k];
        q_r[k]   <= '0;
        sat_r[k] <= {{CH_W{1'b0}}, tm_rd_r.sum[k]} >= {tm_rd_r.cnt, {CH_W{1'b0}}};
      end
    end else if (cmd.div_step) begin
      d_r    <= d_r >> 1;
      dcnt_r <= dcnt_r + DCNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        if (ge[k]) begin
          rem_r[k] <= rem_r[k] - SUM_W'(d_r);
        end
        q_r[k] <= {q_r[k][CH_W-2:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_r     <= '0;
      res_oor_r <= oor_c && ((in_opcode == OP_WRITE) || (in_opcode == OP_READ));
    end else if (cmd.select && !mosaic_r) begin
      res_r <= fs_rd_r;
    end else if (cmd.div_step && stat.div_last) begin
      for (int k = 0; k < 3; k++) begin
        res_r[k] <= sat_r[k] ? {CH_W{1'b1}} : {q_r[k][CH_W-2:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_red_out      <= res_r[0];
      out_green_out    <= res_r[1];
      out_blue_out     <= res_r[2];
      out_out_of_range <= res_oor_r;
    end
  end

  always_comb begin
    stat.in_oor     = oor_c;
    stat.mosaic     = mosaic_r;
    stat.cnt_zero   = (tm_rd_r.cnt == '0);
    stat.sweep_last = (sweep_r == TILE_AW'(NUM_TILES - 1));
    stat.div_last   = (dcnt_r == DCNT_W'(CH_W - 1));
  end

endmodule

// ----- rtl/lhbm_ctrl.sv -----
// Controller of the left-half block mosaic: sequences one request at a
// time and owns the handshake state. Depends on lhbm_pkg.
module lhbm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_opcode,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  lhbm_pkg::dp_stat_t   stat,
  output lhbm_pkg::ctrl_cmd_t  cmd
);
  import lhbm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_WRITE: state_nxt = stat.in_oor ? S_DONE : S_WRITE;
            OP_READ:  state_nxt = stat.in_oor ? S_DONE : S_READ;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_WRITE:  state_nxt = stat.mosaic ? S_ACCUM : S_DONE;
      S_ACCUM:  state_nxt = S_DONE;
      S_READ:   state_nxt = S_SELECT;
      S_SELECT: state_nxt = (stat.mosaic && !stat.cnt_zero) ? S_DIV : S_DONE;
      S_DIV: begin
        if (stat.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.sweep    = (state_r == S_INIT) || (state_r == S_CLEAR);
    cmd.fs_write = (state_r == S_WRITE);
    cmd.tile_acc = (state_r == S_ACCUM);
    cmd.select   = (state_r == S_SELECT);
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_DONE) && out_free;
    in_stall     = (state_r != S_IDLE);
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/left_half_block_mosaic.sv -----
// Left-half block mosaic: frame store with 16x16 tile averaging on the left
// half of the image. Top level joining lhbm_ctrl and lhbm_dp; uses lhbm_pkg.
//
// A request on the in_ channel is taken when in_valid is high and in_stall
// low; each request gives exactly one result on the out_ channel, taken when
// out_valid is high and out_stall low. Opcode clear zeroes the tile sums,
// write stores a pixel (and, in a mosaic tile, accumulates it), read returns
// the stored pixel or, for a mosaic tile, the truncated average of its tile.
// Requests are handled one at a time; in_stall is high from acceptance until
// the result is in the output register. Write passes the write state and,
// for a mosaic tile, the accumulate state; read passes the read and select
// states and, for a mosaic pixel, the shared bit-per-cycle divider; clear
// zeroes one tile entry per cycle. Out-of-range and unused requests skip
// straight to the result. The next request may be taken the cycle after the
// result is loaded, even while a stalled result still waits on the output.
// After reset all tile memory entries are cleared in one pass with in_stall
// high; configuration writes (cfg_valid, always ready) are taken at any time
// but are meant to be written only while the block is idle.
module left_half_block_mosaic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [lhbm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [lhbm_pkg::COORD_W-1:0]  in_col,
  input  logic [lhbm_pkg::COORD_W-1:0]  in_row,
  input  logic [lhbm_pkg::CH_W-1:0]     in_red_in,
  input  logic [lhbm_pkg::CH_W-1:0]     in_green_in,
  input  logic [lhbm_pkg::CH_W-1:0]     in_blue_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lhbm_pkg::CH_W-1:0]     out_red_out,
  output logic [lhbm_pkg::CH_W-1:0]     out_green_out,
  output logic [lhbm_pkg::CH_W-1:0]     out_blue_out,
  output logic                          out_out_of_range
);
  import lhbm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  lhbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lhbm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_opcode        (in_opcode),
    .in_col           (in_col),
    .in_row           (in_row),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_out_of_range (out_out_of_range)
  );

  // Only one request is ever in flight.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // An out-of-range result carries no colour.
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_red_out == '0 && out_green_out == '0 && out_blue_out == '0))
    else $error("out-of-range result with colour");

  // The tile memory clearing pass holds off requests after reset.
  a_init_stall: assert property (@(posedge clk)
    !rst_n |=> (in_stall && !out_valid))
    else $error("requests not held off after reset");

endmodule
